// File: rtl/lcd_differential_row_update_macros.svh
// assertion macros for the differential row updater checker
// expects clk and rst_n in the scope of use
`ifndef LCD_DIFFERENTIAL_ROW_UPDATE_MACROS_SVH
`define LCD_DIFFERENTIAL_ROW_UPDATE_MACROS_SVH

// next-cycle check, masked while in reset
`define LCDROW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle check that also runs through reset
`define LCDROW_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lcdrow_pkg.sv
// shared types and constants for the differential row updater
// no dependencies
`timescale 1ns / 1ps

package lcdrow_pkg;

  localparam int DEF_COLUMNS = 20;
  localparam int DEF_ROWS    = 4;
  localparam int BANKS       = 2;
  localparam int JOBQ_DEPTH  = BANKS;
  localparam int OBUF_DEPTH  = 4;

  localparam logic [7:0] PREFIX_RESET = 8'hFE;
  localparam logic [7:0] CMD_GOTO     = 8'h47;
  localparam logic [7:0] CMD_HOME     = 8'h48;

  typedef struct packed {
    logic [7:0] old_char;
    logic [7:0] new_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

endpackage

// File: rtl/lcdrow_front.sv
// front end: takes cells, writes the row buffer, tracks change mask and estimate
// pushes one job per row end of row 0 or of a row with a change; depends on lcdrow_pkg
`timescale 1ns / 1ps

module lcdrow_front #(
  parameter int COLUMNS = lcdrow_pkg::DEF_COLUMNS,
  parameter int ROWS    = lcdrow_pkg::DEF_ROWS,
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = (ROWS > 1) ? $clog2(ROWS) : 1,
  parameter int JOB_W   = COLUMNS + RW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcdrow_pkg::in_item_t in_data,
  input  logic                 job_done,
  output logic                 job_push,
  output logic [JOB_W-1:0]     job_data,
  output logic                 mem_we,
  output logic [CW:0]          mem_addr,
  output logic [7:0]           mem_wdata
);
  import lcdrow_pkg::*;

  localparam int EST_W = $clog2(3 * COLUMNS + 1);

  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [COLUMNS-1:0] mask_r, mask_nxt, mask_upd;
  logic [EST_W-1:0]   est_r, est_nxt, est_upd, est_inc;
  logic               prev_r, prev_nxt;
  logic               bank_r, bank_nxt;
  logic [1:0]         jobs_r, jobs_nxt;
  logic               accept, changed, last_col, full;

  assign in_ready = (int'(jobs_r) < BANKS);
  assign accept   = in_valid && in_ready;
  assign changed  = (in_data.old_char != in_data.new_char);
  assign last_col = (col_r == CW'(COLUMNS - 1));

  always_comb begin
    mask_upd = mask_r;
    est_inc  = '0;
    if (changed) begin
      mask_upd = mask_r | (COLUMNS'(1) << col_r);
      est_inc  = ((col_r != '0) && !prev_r) ? EST_W'(5) : EST_W'(1);
    end
    est_upd = est_r + est_inc;
  end

  assign full     = (est_upd > EST_W'(COLUMNS));
  assign job_push = accept && last_col && ((row_r == '0) || (mask_upd != '0));
  assign job_data = {mask_upd, full, row_r, bank_r};

  assign mem_we    = accept;
  assign mem_addr  = {bank_r, col_r};
  assign mem_wdata = in_data.new_char;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    mask_nxt = mask_r;
    est_nxt  = est_r;
    prev_nxt = prev_r;
    bank_nxt = bank_r;
    if (accept) begin
      if (last_col) begin
        col_nxt  = '0;
        row_nxt  = (row_r == RW'(ROWS - 1)) ? '0 : row_r + RW'(1);
        mask_nxt = '0;
        est_nxt  = '0;
        prev_nxt = 1'b0;
        if (job_push) begin
          bank_nxt = !bank_r;
        end
      end else begin
        col_nxt  = col_r + CW'(1);
        mask_nxt = mask_upd;
        est_nxt  = est_upd;
        prev_nxt = changed;
      end
    end
    jobs_nxt = jobs_r + {1'b0, job_push} - {1'b0, job_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      mask_r <= '0;
      est_r  <= '0;
      prev_r <= 1'b0;
      bank_r <= 1'b0;
      jobs_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      mask_r <= mask_nxt;
      est_r  <= est_nxt;
      prev_r <= prev_nxt;
      bank_r <= bank_nxt;
      jobs_r <= jobs_nxt;
    end
  end

endmodule

// File: rtl/lcdrow_jobq.sv
// row job queue between front and back end
// depends on lcdrow_pkg
`timescale 1ns / 1ps

module lcdrow_jobq #(
  parameter int W     = 8,
  parameter int DEPTH = lcdrow_pkg::JOBQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);
  import lcdrow_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/lcdrow_back.sv
// back end: row buffer memory, command sequencer and byte read stage
// depends on lcdrow_pkg
`timescale 1ns / 1ps

module lcdrow_back #(
  parameter int COLUMNS = lcdrow_pkg::DEF_COLUMNS,
  parameter int ROWS    = lcdrow_pkg::DEF_ROWS,
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = (ROWS > 1) ? $clog2(ROWS) : 1,
  parameter int JOB_W   = COLUMNS + RW + 2,
  parameter int OCW     = $clog2(lcdrow_pkg::OBUF_DEPTH) + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  job_valid,
  input  logic [JOB_W-1:0]      job_data,
  output logic                  job_pop,
  output logic                  job_done,
  input  logic                  mem_we,
  input  logic [CW:0]           mem_addr,
  input  logic [7:0]            mem_wdata,
  input  logic [OCW-1:0]        ob_count,
  output logic                  push_valid,
  output lcdrow_pkg::out_item_t push_data
);
  import lcdrow_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_HOME_P = 9'b000000010,
    ST_HOME_H = 9'b000000100,
    ST_GOTO_P = 9'b000001000,
    ST_GOTO_G = 9'b000010000,
    ST_GOTO_C = 9'b000100000,
    ST_GOTO_R = 9'b001000000,
    ST_SCAN   = 9'b010000000,
    ST_FULL   = 9'b100000000
  } bst_t;

  bst_t               st_r, st_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [COLUMNS-1:0] mask_r, mask_nxt;
  logic               full_r, full_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic               bank_r, bank_nxt;
  logic               open_r, open_nxt;
  logic [7:0]         prefix_r;

  logic [7:0] row_mem_r [2**(CW+1)];
  logic [7:0] mem_q_r;

  logic       p_valid_r, p_char_r, p_last_r;
  logic [7:0] p_byte_r;

  logic       room, emit, e_char, e_last, rest_empty;
  logic [7:0] e_byte;

  assign room       = (int'(ob_count) + int'(p_valid_r)) < OBUF_DEPTH;
  assign rest_empty = (mask_r[COLUMNS-1:1] == '0);

  always_comb begin
    st_nxt   = st_r;
    col_nxt  = col_r;
    mask_nxt = mask_r;
    full_nxt = full_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    open_nxt = open_r;
    job_pop  = 1'b0;
    job_done = 1'b0;
    emit     = 1'b0;
    e_char   = 1'b0;
    e_last   = 1'b0;
    e_byte   = '0;
    case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop  = 1'b1;
          bank_nxt = job_data[0];
          row_nxt  = job_data[RW:1];
          full_nxt = job_data[RW+1];
          mask_nxt = job_data[JOB_W-1 -: COLUMNS];
          col_nxt  = '0;
          open_nxt = 1'b0;
          if (job_data[RW:1] == '0) begin
            st_nxt = ST_HOME_P;
          end else if (job_data[RW+1]) begin
            st_nxt = ST_GOTO_P;
          end else begin
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_HOME_P: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = prefix_r;
          st_nxt = ST_HOME_H;
        end
      end
      ST_HOME_H: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = CMD_HOME;
          if (full_r) begin
            st_nxt = ST_GOTO_P;
          end else if (mask_r == '0) begin
            e_last   = 1'b1;
            job_done = 1'b1;
            st_nxt   = ST_IDLE;
          end else begin
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_GOTO_P: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = prefix_r;
          st_nxt = ST_GOTO_G;
        end
      end
      ST_GOTO_G: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = CMD_GOTO;
          st_nxt = ST_GOTO_C;
        end
      end
      ST_GOTO_C: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = 8'(col_r) + 8'd1;
          st_nxt = ST_GOTO_R;
        end
      end
      ST_GOTO_R: begin
        if (room) begin
          emit     = 1'b1;
          e_byte   = 8'(row_r) + 8'd1;
          open_nxt = 1'b1;
          st_nxt   = full_r ? ST_FULL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (mask_r[0]) begin
          if (!open_r) begin
            st_nxt = ST_GOTO_P;
          end else if (room) begin
            emit     = 1'b1;
            e_char   = 1'b1;
            e_last   = rest_empty;
            mask_nxt = mask_r >> 1;
            col_nxt  = col_r + CW'(1);
            if (rest_empty) begin
              job_done = 1'b1;
              st_nxt   = ST_IDLE;
            end
          end
        end else begin
          open_nxt = 1'b0;
          mask_nxt = mask_r >> 1;
          col_nxt  = col_r + CW'(1);
        end
      end
      ST_FULL: begin
        if (room) begin
          emit    = 1'b1;
          e_char  = 1'b1;
          e_last  = (col_r == CW'(COLUMNS - 1));
          col_nxt = col_r + CW'(1);
          if (col_r == CW'(COLUMNS - 1)) begin
            job_done = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // row buffer, two banks
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem_r[mem_addr] <= mem_wdata;
    end
    mem_q_r <= row_mem_r[{bank_r, col_r}];
  end

  always_ff @(posedge clk) begin
    p_char_r <= e_char;
    p_last_r <= e_last;
    p_byte_r <= e_byte;
  end

  assign push_valid            = p_valid_r;
  assign push_data.out_byte    = p_char_r ? mem_q_r : p_byte_r;
  assign push_data.last_of_run = p_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      col_r     <= '0;
      mask_r    <= '0;
      full_r    <= 1'b0;
      row_r     <= '0;
      bank_r    <= 1'b0;
      open_r    <= 1'b0;
      prefix_r  <= PREFIX_RESET;
      p_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      col_r     <= col_nxt;
      mask_r    <= mask_nxt;
      full_r    <= full_nxt;
      row_r     <= row_nxt;
      bank_r    <= bank_nxt;
      open_r    <= open_nxt;
      p_valid_r <= emit;
      if (cfg_we) begin
        prefix_r <= cfg_wdata;
      end
    end
  end

endmodule

// File: rtl/lcdrow_obuf.sv
// output queue holding command bytes until the sink takes them
// depends on lcdrow_pkg
`timescale 1ns / 1ps

module lcdrow_obuf #(
  parameter int DEPTH = lcdrow_pkg::OBUF_DEPTH,
  parameter int OCW   = $clog2(DEPTH) + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lcdrow_pkg::out_item_t push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lcdrow_pkg::out_item_t out_data,
  output logic [OCW-1:0]        count
);
  import lcdrow_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  out_item_t     slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [OCW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + {{(OCW-1){1'b0}}, push} - {{(OCW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/lcd_differential_row_update.sv
// one cell per cycle is taken while one of the two row buffer banks is free; a cell
// stalls only when two finished rows still wait on the back end
// row end, back end free: the job passes the job queue and the sequencer, whose bytes are
// registered into the output queue; then one byte per cycle while that queue has room,
// pausing per unchanged column skipped and per change run opened in the run scan
// synchronous active-low reset clears control state, sets the prefix to 0xFE, keeps row buffer
`timescale 1ns / 1ps

module lcd_differential_row_update #(
  parameter int COLUMNS = lcdrow_pkg::DEF_COLUMNS,
  parameter int ROWS    = lcdrow_pkg::DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lcdrow_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lcdrow_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);
  import lcdrow_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int JOB_W = COLUMNS + RW + 2;
  localparam int OCW   = $clog2(OBUF_DEPTH) + 1;

  logic             job_push, job_pop, job_done, job_valid;
  logic [JOB_W-1:0] job_in, job_out;
  logic             mem_we;
  logic [CW:0]      mem_addr;
  logic [7:0]       mem_wdata;
  logic [OCW-1:0]   ob_count;
  logic             push_valid;
  out_item_t        push_data;

  lcdrow_front #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .CW(CW), .RW(RW), .JOB_W(JOB_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_done (job_done),
    .job_push (job_push),
    .job_data (job_in),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata)
  );

  lcdrow_jobq #(
    .W(JOB_W), .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_in),
    .pop      (job_pop),
    .pop_data (job_out),
    .not_empty(job_valid)
  );

  lcdrow_back #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .CW(CW), .RW(RW), .JOB_W(JOB_W), .OCW(OCW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_valid (job_valid),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .job_done  (job_done),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .ob_count  (ob_count),
    .push_valid(push_valid),
    .push_data (push_data)
  );

  lcdrow_obuf #(
    .DEPTH(OBUF_DEPTH), .OCW(OCW)
  ) u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_data(push_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .count    (ob_count)
  );

endmodule

// File: rtl/lcdrow_checker.sv
// port-level checks for the differential row updater, bound to the top level
// depends on lcdrow_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "lcd_differential_row_update_macros.svh"

module lcdrow_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input lcdrow_pkg::out_item_t out_data
);
  import lcdrow_pkg::*;

  // a stalled result holds
  `LCDROW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  // ready only drops after a cell transfer
  `LCDROW_ASSERT_NEXT(a_ready_keep, in_ready && !in_valid, in_ready, "in_ready fell without a transfer")
  // reset leaves no result pending and the input open
  `LCDROW_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && in_ready, "state not cleared by reset")

endmodule

bind lcd_differential_row_update lcdrow_checker u_chk (.*);
